FILE: rtl/core/obep_pkg.sv
// Shared types, constants and the scaled dot-product function for the
// oriented box extent projector. No dependencies.
package obep_pkg;

   localparam int COORD_WIDTH     = 32;
   localparam int AXIS_FRAC_BITS  = 14;
   localparam int AXIS_COMP_WIDTH = 16;
   localparam int REG_WIDTH       = 3 * AXIS_COMP_WIDTH;
   localparam int CSR_IDX_WIDTH   = 2;

   // product of a widened coordinate and one axis component, and the
   // three-term sum with rounding headroom
   localparam int PROD_WIDTH = COORD_WIDTH + 1 + AXIS_COMP_WIDTH;
   localparam int DOT_WIDTH  = PROD_WIDTH + 2;
   localparam int QUOT_WIDTH = DOT_WIDTH - AXIS_FRAC_BITS;

   typedef logic signed [COORD_WIDTH-1:0]     coord_type;
   typedef logic signed [COORD_WIDTH:0]       wcoord_type;
   typedef logic        [COORD_WIDTH-2:0]     half_type;
   typedef logic signed [AXIS_COMP_WIDTH-1:0] comp_type;
   typedef logic        [CSR_IDX_WIDTH-1:0]   csr_idx_type;
   typedef logic        [REG_WIDTH-1:0]       csr_data_type;

   // x in the low bits, z in the high bits
   typedef struct packed {
      comp_type z;
      comp_type y;
      comp_type x;
   } axis_type;

   // one projected point on its way to the extent registers
   typedef struct packed {
      logic                  last;
      coord_type [2:0]       p;
   } proj_type;

   // finished extents of one point set
   typedef struct packed {
      coord_type [2:0] lo;
      coord_type [2:0] hi;
   } box_type;

   localparam csr_idx_type CSR_AXIS_U = csr_idx_type'(0);
   localparam csr_idx_type CSR_AXIS_V = csr_idx_type'(1);
   localparam csr_idx_type CSR_AXIS_W = csr_idx_type'(2);

   localparam coord_type COORD_MAX = coord_type'({1'b0, {(COORD_WIDTH-1){1'b1}}});
   localparam coord_type COORD_MIN = coord_type'({1'b1, {(COORD_WIDTH-1){1'b0}}});
   localparam comp_type  AXIS_ONE  = comp_type'(1) <<< AXIS_FRAC_BITS;

   localparam logic signed [DOT_WIDTH-1:0] DOT_ROUND =
      DOT_WIDTH'(1) <<< (AXIS_FRAC_BITS - 1);

   // (a . b) / 2^AXIS_FRAC_BITS, rounded half up, saturated
   function automatic coord_type scaled_dot(input wcoord_type a0, input wcoord_type a1,
                                            input wcoord_type a2, input comp_type b0,
                                            input comp_type b1, input comp_type b2);
      logic signed [PROD_WIDTH-1:0] p0;
      logic signed [PROD_WIDTH-1:0] p1;
      logic signed [PROD_WIDTH-1:0] p2;
      logic signed [DOT_WIDTH-1:0]  acc;
      logic        [QUOT_WIDTH-1:0] q;
      logic        [QUOT_WIDTH-COORD_WIDTH:0] top;
      p0  = a0 * b0;
      p1  = a1 * b1;
      p2  = a2 * b2;
      acc = DOT_WIDTH'(p0) + DOT_WIDTH'(p1) + DOT_WIDTH'(p2) + DOT_ROUND;
      q   = acc[DOT_WIDTH-1:AXIS_FRAC_BITS];
      top = q[QUOT_WIDTH-1:COORD_WIDTH-1];
      if ((&top) || !(|top)) begin
         return coord_type'(q[COORD_WIDTH-1:0]);
      end else if (q[QUOT_WIDTH-1]) begin
         return COORD_MIN;
      end else begin
         return COORD_MAX;
      end
   endfunction

endpackage

FILE: rtl/core/obep_if.sv
// Channel interfaces of the oriented box extent projector: point requests,
// corner results and register writes. Depends on obep_pkg.
interface obep_req_if;
   logic                valid;
   logic                ready;
   obep_pkg::coord_type point_x;
   obep_pkg::coord_type point_y;
   obep_pkg::coord_type point_z;
   logic                last_point;

   modport source (output valid, point_x, point_y, point_z, last_point, input ready);
   modport sink   (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface obep_rsp_if;
   logic                valid;
   logic                ready;
   obep_pkg::coord_type corner_x;
   obep_pkg::coord_type corner_y;
   obep_pkg::coord_type corner_z;
   obep_pkg::coord_type center_x;
   obep_pkg::coord_type center_y;
   obep_pkg::coord_type center_z;
   obep_pkg::half_type  half_u;
   obep_pkg::half_type  half_v;
   obep_pkg::half_type  half_w;
   logic [2:0]          corner_index;
   logic                last_corner;

   modport source (output valid, corner_x, corner_y, corner_z, center_x, center_y,
                   center_z, half_u, half_v, half_w, corner_index, last_corner,
                   input ready);
   modport sink   (input valid, corner_x, corner_y, corner_z, center_x, center_y,
                   center_z, half_u, half_v, half_w, corner_index, last_corner,
                   output ready);
endinterface

interface obep_csr_if;
   logic                   valid;
   logic                   ready;
   obep_pkg::csr_idx_type  index;
   obep_pkg::csr_data_type data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/oriented_box_extent_projector.sv
// Top level of the oriented box extent projector: axis registers and the
// projection, extent and corner stages. Depends on obep_pkg, obep_if and
// obep_project, obep_extent, obep_corner.
//
// Usage:
//  - req carries one point per request (Q16.16 x/y/z) and last_point, which
//    closes a point set. A request is taken when valid and ready are high.
//  - rsp returns eight corner results per set, corner_index 0..7 in order,
//    last_corner on the eighth. Each carries the corner, the box center and
//    the three half extents.
//  - csr writes the three Q2.14 axes (index 0 = u, 1 = v, 2 = w); ready is
//    always high. Write only while no set is in flight.
//  - Throughput: one point per cycle, but a set's last point waits in the
//    extent stage while the corner generator is busy with the previous set
//    (load, prep state, then the eight corners).
//  - The first corner of a set shows on rsp after its last point passes the
//    input reg, projection reg, extent load, prep and result reg, then one
//    corner per cycle while rsp.ready is high.
//  - A stalled rsp holds its result; points keep flowing into the extents
//    until a second last point reaches the busy corner generator.
//  - Reset (synchronous) empties every stage, clears the extents and loads
//    the axes with the identity basis.
module oriented_box_extent_projector (
   input  logic       clock,
   input  logic       reset,
   obep_req_if.sink   req,
   obep_rsp_if.source rsp,
   obep_csr_if.sink   csr
);
   import obep_pkg::*;

   axis_type axis_u_ff, axis_u_in;
   axis_type axis_v_ff, axis_v_in;
   axis_type axis_w_ff, axis_w_in;

   logic     proj_valid;
   logic     proj_ready;
   proj_type proj;
   logic     box_valid;
   logic     box_ready;
   box_type  box;

   // register writes are always accepted; unused indexes are dropped
   assign csr.ready = 1'b1;

   always_comb begin
      axis_u_in = axis_u_ff;
      axis_v_in = axis_v_ff;
      axis_w_in = axis_w_ff;
      if (csr.valid) begin
         unique case (csr.index)
            CSR_AXIS_U: axis_u_in = axis_type'(csr.data);
            CSR_AXIS_V: axis_v_in = axis_type'(csr.data);
            CSR_AXIS_W: axis_w_in = axis_type'(csr.data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_u_ff <= '{z: '0, y: '0, x: AXIS_ONE};
         axis_v_ff <= '{z: '0, y: AXIS_ONE, x: '0};
         axis_w_ff <= '{z: AXIS_ONE, y: '0, x: '0};
      end else begin
         axis_u_ff <= axis_u_in;
         axis_v_ff <= axis_v_in;
         axis_w_ff <= axis_w_in;
      end
   end

   // point -> three projections, input register then projection register
   obep_project u_project (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .axis_u     (axis_u_ff),
      .axis_v     (axis_v_ff),
      .axis_w     (axis_w_ff),
      .proj_valid (proj_valid),
      .proj_ready (proj_ready),
      .proj       (proj)
   );

   // running min/max; a last point hands the set over and clears the extents
   obep_extent u_extent (
      .clock      (clock),
      .reset      (reset),
      .proj_valid (proj_valid),
      .proj_ready (proj_ready),
      .proj       (proj),
      .box_valid  (box_valid),
      .box_ready  (box_ready),
      .box        (box)
   );

   // center, half extents and the eight corners back in world space
   obep_corner u_corner (
      .clock     (clock),
      .reset     (reset),
      .box_valid (box_valid),
      .box_ready (box_ready),
      .box       (box),
      .axis_u    (axis_u_ff),
      .axis_v    (axis_v_ff),
      .axis_w    (axis_w_ff),
      .rsp       (rsp)
   );

endmodule

FILE: rtl/core/obep_project.sv
// Input register and projection stage: three scaled dot products per point.
// Depends on obep_pkg and obep_if.
module obep_project (
   input  logic               clock,
   input  logic               reset,
   obep_req_if.sink           req,
   input  obep_pkg::axis_type axis_u,
   input  obep_pkg::axis_type axis_v,
   input  obep_pkg::axis_type axis_w,
   output logic               proj_valid,
   input  logic               proj_ready,
   output obep_pkg::proj_type proj
);
   import obep_pkg::*;

   logic       in_valid_ff, in_valid_in;
   coord_type  px_ff, py_ff, pz_ff;
   logic       in_last_ff;
   logic       pr_valid_ff, pr_valid_in;
   proj_type   pr_ff, pr_in;
   logic       pr_adv;
   wcoord_type wx, wy, wz;

   assign pr_adv    = !pr_valid_ff || proj_ready;
   assign req.ready = !in_valid_ff || pr_adv;

   assign wx = wcoord_type'(px_ff);
   assign wy = wcoord_type'(py_ff);
   assign wz = wcoord_type'(pz_ff);

   always_comb begin
      in_valid_in = req.ready ? req.valid : in_valid_ff;
      pr_valid_in = pr_adv ? in_valid_ff : pr_valid_ff;
      pr_in.last  = in_last_ff;
      pr_in.p[0]  = scaled_dot(wx, wy, wz, axis_u.x, axis_u.y, axis_u.z);
      pr_in.p[1]  = scaled_dot(wx, wy, wz, axis_v.x, axis_v.y, axis_v.z);
      pr_in.p[2]  = scaled_dot(wx, wy, wz, axis_w.x, axis_w.y, axis_w.z);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         pr_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         pr_valid_ff <= pr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         px_ff      <= req.point_x;
         py_ff      <= req.point_y;
         pz_ff      <= req.point_z;
         in_last_ff <= req.last_point;
      end
      if (pr_adv && in_valid_ff) begin
         pr_ff <= pr_in;
      end
   end

   assign proj_valid = pr_valid_ff;
   assign proj       = pr_ff;

endmodule

FILE: rtl/core/obep_extent.sv
// Running min/max of the projections along the three axes; hands the
// finished extents to the corner generator on the last point. Depends on obep_pkg.
module obep_extent (
   input  logic               clock,
   input  logic               reset,
   input  logic               proj_valid,
   output logic               proj_ready,
   input  obep_pkg::proj_type proj,
   output logic               box_valid,
   input  logic               box_ready,
   output obep_pkg::box_type  box
);
   import obep_pkg::*;

   coord_type lo_ff [3];
   coord_type hi_ff [3];
   coord_type lo_in [3];
   coord_type hi_in [3];
   coord_type lo_nx [3];
   coord_type hi_nx [3];
   logic      take;

   // a last point waits until the corner generator is free
   assign proj_ready = !proj_valid || !proj.last || box_ready;
   assign take       = proj_valid && proj_ready;
   assign box_valid  = proj_valid && proj.last;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         lo_nx[i] = ($signed(proj.p[i]) < lo_ff[i]) ? $signed(proj.p[i]) : lo_ff[i];
         hi_nx[i] = ($signed(proj.p[i]) > hi_ff[i]) ? $signed(proj.p[i]) : hi_ff[i];
         box.lo[i] = lo_nx[i];
         box.hi[i] = hi_nx[i];
         if (!take) begin
            lo_in[i] = lo_ff[i];
            hi_in[i] = hi_ff[i];
         end else if (proj.last) begin
            lo_in[i] = COORD_MAX;
            hi_in[i] = COORD_MIN;
         end else begin
            lo_in[i] = lo_nx[i];
            hi_in[i] = hi_nx[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= COORD_MAX;
            hi_ff[i] <= COORD_MIN;
         end
      end else begin
         for (int i = 0; i < 3; i++) begin
            lo_ff[i] <= lo_in[i];
            hi_ff[i] <= hi_in[i];
         end
      end
   end

endmodule

FILE: rtl/core/obep_corner.sv
// Corner generator: turns one set of extents into center and half extents,
// then emits the eight world-space corners through the result register.
// Depends on obep_pkg and obep_if.
module obep_corner (
   input  logic               clock,
   input  logic               reset,
   input  logic               box_valid,
   output logic               box_ready,
   input  obep_pkg::box_type  box,
   input  obep_pkg::axis_type axis_u,
   input  obep_pkg::axis_type axis_v,
   input  obep_pkg::axis_type axis_w,
   obep_rsp_if.source         rsp
);
   import obep_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PREP,
      ST_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] k_ff, k_in;
   logic       out_valid_ff, out_valid_in;
   logic       emit;

   coord_type  lo_ff [3];
   coord_type  hi_ff [3];
   coord_type  c_ff  [3];
   half_type   h_ff  [3];

   wcoord_type sum   [3];
   wcoord_type diff  [3];
   wcoord_type cw    [3];
   wcoord_type t     [3];
   coord_type  corner_in [3];
   coord_type  center_in [3];

   coord_type  corner_ff [3];
   coord_type  center_ff [3];
   half_type   half_ff   [3];
   logic [2:0] index_ff;
   logic       last_ff;

   assign box_ready = (state_ff == ST_IDLE);
   assign emit      = (state_ff == ST_EMIT) && (!out_valid_ff || rsp.ready);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i]  = wcoord_type'(hi_ff[i]) + wcoord_type'(lo_ff[i]);
         diff[i] = wcoord_type'(hi_ff[i]) - wcoord_type'(lo_ff[i]);
         cw[i]   = wcoord_type'(c_ff[i]);
         // index bit 2 is the u sign, bit 0 the w sign
         if (k_ff[2-i]) begin
            t[i] = cw[i] - $signed({2'b00, h_ff[i]});
         end else begin
            t[i] = cw[i] + $signed({2'b00, h_ff[i]});
         end
      end
      corner_in[0] = scaled_dot(t[0], t[1], t[2], axis_u.x, axis_v.x, axis_w.x);
      corner_in[1] = scaled_dot(t[0], t[1], t[2], axis_u.y, axis_v.y, axis_w.y);
      corner_in[2] = scaled_dot(t[0], t[1], t[2], axis_u.z, axis_v.z, axis_w.z);
      center_in[0] = scaled_dot(cw[0], cw[1], cw[2], axis_u.x, axis_v.x, axis_w.x);
      center_in[1] = scaled_dot(cw[0], cw[1], cw[2], axis_u.y, axis_v.y, axis_w.y);
      center_in[2] = scaled_dot(cw[0], cw[1], cw[2], axis_u.z, axis_v.z, axis_w.z);
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      unique case (state_ff)
         ST_IDLE: begin
            if (box_valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            state_in = ST_EMIT;
            k_in     = '0;
         end
         ST_EMIT: begin
            if (emit) begin
               out_valid_in = 1'b1;
               k_in         = k_ff + 3'd1;
               if (&k_ff) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         k_ff         <= k_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < 3; i++) begin
            if (box_valid && box_ready) begin
               lo_ff[i] <= $signed(box.lo[i]);
               hi_ff[i] <= $signed(box.hi[i]);
            end
            if (state_ff == ST_PREP) begin
               c_ff[i] <= coord_type'(sum[i][COORD_WIDTH:1]);
               h_ff[i] <= diff[i][COORD_WIDTH-1:1];
            end
            if (emit) begin
               corner_ff[i] <= corner_in[i];
               center_ff[i] <= center_in[i];
               half_ff[i]   <= h_ff[i];
            end
         end
         if (emit) begin
            index_ff <= k_ff;
            last_ff  <= &k_ff;
         end
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.corner_x     = corner_ff[0];
   assign rsp.corner_y     = corner_ff[1];
   assign rsp.corner_z     = corner_ff[2];
   assign rsp.center_x     = center_ff[0];
   assign rsp.center_y     = center_ff[1];
   assign rsp.center_z     = center_ff[2];
   assign rsp.half_u       = half_ff[0];
   assign rsp.half_v       = half_ff[1];
   assign rsp.half_w       = half_ff[2];
   assign rsp.corner_index = index_ff;
   assign rsp.last_corner  = last_ff;

endmodule
